// ===== rtl/acc_pkg.sv =====
`default_nettype none

package acc_pkg;

   // Item operation codes
   localparam logic [1:0] OpLoad = 2'd0;
   localparam logic [1:0] OpExec = 2'd1;
   localparam logic [1:0] OpRead = 2'd2;

   // Addressing modes, bits 1..0 of the opcode word
   localparam logic [1:0] ModeAbs = 2'd0;
   localparam logic [1:0] ModeLit = 2'd1;
   localparam logic [1:0] ModeIdx = 2'd2;
   localparam logic [1:0] ModeRel = 2'd3;

   // Opcode word layout
   localparam logic [15:0] ModeMask = 16'h0003;
   localparam logic [15:0] DirMask  = 16'h0004;
   localparam int unsigned CodeLsb  = 4;

   // Instruction codes, bits 15..4 of the opcode word
   localparam logic [11:0] CodeMove = 12'd0;
   localparam logic [11:0] CodeAdd  = 12'd1;
   localparam logic [11:0] CodeSub  = 12'd2;
   localparam logic [11:0] CodeBra  = 12'd3;
   localparam logic [11:0] CodeCmp  = 12'd4;
   localparam logic [11:0] CodeBeq  = 12'd5;
   localparam logic [11:0] CodeBne  = 12'd6;
   localparam logic [11:0] CodeExg  = 12'd7;
   localparam logic [11:0] CodeStop = 12'd15;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  mem_address;
      logic [15:0] mem_data;
   } req_word_type;

   typedef struct packed {
      logic [15:0] data_reg;
      logic [15:0] address_reg;
      logic [15:0] program_counter;
      logic        zero_flag;
      logic        halted;
      logic [15:0] read_word;
   } rsp_word_type;

   // Architectural registers of the core
   typedef struct packed {
      logic [15:0] data_reg;
      logic [15:0] address_reg;
      logic [15:0] program_counter;
      logic [15:0] held;
      logic        zero_flag;
      logic        halted;
   } cpu_regs_type;

endpackage

`default_nettype wire

// ===== rtl/acc_ram.sv =====
`default_nettype none

module acc_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write on enable, register the read
   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[addr] <= wdata;
      end
      rdata_ff <= store_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/acc_wrap.sv =====
`default_nettype none

// Reduce a 16-bit address modulo MEM_DEPTH by reciprocal multiplication.
// The index is formed from the product register and then the multiple register.
module acc_wrap #(
   parameter int unsigned MEM_DEPTH = 256
) (
   input  logic                         clock,
   input  logic [15:0]                  addr,
   output logic [$clog2(MEM_DEPTH)-1:0] idx
);

   localparam int unsigned AddrW     = $clog2(MEM_DEPTH);
   localparam int unsigned RecipBits = 33 - AddrW;
   localparam logic [63:0] Recip64   =
      ((64'd1 << 32) + 64'(MEM_DEPTH) - 64'd1) / 64'(MEM_DEPTH);
   localparam logic [RecipBits-1:0] Recip = Recip64[RecipBits-1:0];

   logic [16+RecipBits-1:0] prod_ff;
   logic [15:0]             addr_ff;
   logic [15:0]             quot;
   logic [16:0]             mult_ff;
   logic [15:0]             addr2_ff;
   logic [16:0]             diff;

   // Estimate the quotient; exact for all 16-bit inputs
   assign quot = 16'(prod_ff >> 32);

   always_ff @(posedge clock) begin
      prod_ff  <= (16+RecipBits)'(addr) * (16+RecipBits)'(Recip);
      addr_ff  <= addr;
      mult_ff  <= 17'(17'(quot) * 17'(MEM_DEPTH));
      addr2_ff <= addr_ff;
   end

   // Take the remainder
   assign diff = 17'(addr2_ff) - mult_ff;
   assign idx  = diff[AddrW-1:0];

endmodule

`default_nettype wire

// ===== rtl/acc_exec.sv =====
`default_nettype none

// Execute one decoded instruction on the register set.
module acc_exec (
   input  acc_pkg::cpu_regs_type cur,
   input  logic [15:0]           opword,
   input  logic [15:0]           operand,
   input  logic [15:0]           source,
   output acc_pkg::cpu_regs_type nxt
);

   logic [1:0]  mode;
   logic        dir_in;
   logic [11:0] code;
   logic [15:0] sum;
   logic [15:0] dif;
   logic [15:0] branch_pc;

   assign mode   = 2'(opword & acc_pkg::ModeMask);
   assign dir_in = |(opword & acc_pkg::DirMask);
   assign code   = opword[15:acc_pkg::CodeLsb];
   assign sum    = cur.data_reg + source;
   assign dif    = cur.data_reg - source;

   // Branch target: absolute in absolute mode, PC-relative in literal mode, other modes leave the PC
   always_comb begin
      case (mode)
         acc_pkg::ModeAbs: begin
            branch_pc = operand;
         end
         acc_pkg::ModeLit: begin
            branch_pc = cur.program_counter + operand;
         end
         default: begin
            branch_pc = cur.program_counter;
         end
      endcase
   end

   always_comb begin
      nxt = cur;
      case (code)
         acc_pkg::CodeMove: begin
            if (dir_in) begin
               nxt.data_reg  = source;
               nxt.zero_flag = (source == 16'd0);
            end else begin
               nxt.held      = cur.data_reg;
               nxt.zero_flag = (cur.data_reg == 16'd0);
            end
         end
         acc_pkg::CodeAdd: begin
            if (dir_in) begin
               nxt.data_reg = sum;
            end else begin
               nxt.held = sum;
            end
            nxt.zero_flag = (sum == 16'd0);
         end
         acc_pkg::CodeSub: begin
            if (dir_in) begin
               nxt.data_reg = dif;
            end else begin
               nxt.held = dif;
            end
            nxt.zero_flag = (dif == 16'd0);
         end
         acc_pkg::CodeBra: begin
            nxt.program_counter = branch_pc;
         end
         acc_pkg::CodeCmp: begin
            nxt.zero_flag = (dif == 16'd0);
         end
         acc_pkg::CodeBeq: begin
            if (cur.zero_flag) begin
               nxt.program_counter = branch_pc;
            end
         end
         acc_pkg::CodeBne: begin
            if (!cur.zero_flag) begin
               nxt.program_counter = branch_pc;
            end
         end
         acc_pkg::CodeExg: begin
            nxt.data_reg    = cur.address_reg;
            nxt.address_reg = cur.data_reg;
         end
         acc_pkg::CodeStop: begin
            nxt.halted = 1'b1;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/accumulator_cpu_core_top.sv =====
`default_nettype none

// Accumulator CPU core.
// Input: drive req_word and raise start; the word is taken at a clock edge
// where start is high and busy is low. Each word gives exactly one result,
// shown on rsp_word for one cycle while rsp_strobe is high; the receiver
// cannot stall it. busy falls the cycle after the strobe.
// Memory state lives in one single-port memory of MEM_DEPTH words with a
// registered read. Every address but the clearing pass's goes through a
// two-stage modulo unit; an access waits until the counter reaches WaitLast,
// and a read takes the data in its Q state. Ignored words (unused operation
// or execute after STOP) go straight to the strobe; load and read reduce one
// address. Execute fetches the opcode and operand words, then the source
// unless the mode is literal, executes, and writes back if the direction bit
// is clear and the mode is not literal. The next word can be taken in the
// cycle after the strobe. Reset: the architectural registers clear at once,
// then a clearing pass zeroes every memory word, one per cycle, busy high.
module accumulator_cpu_core_top #(
   parameter int unsigned MEM_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  acc_pkg::req_word_type req_word,
   output logic                  busy,
   output logic                  rsp_strobe,
   output acc_pkg::rsp_word_type rsp_word
);

   localparam int unsigned AddrW = $clog2(MEM_DEPTH);

   localparam logic [3:0] StClear = 4'd0;
   localparam logic [3:0] StIdle  = 4'd1;
   localparam logic [3:0] StLoad  = 4'd2;
   localparam logic [3:0] StRead  = 4'd3;
   localparam logic [3:0] StReadQ = 4'd4;
   localparam logic [3:0] StFop   = 4'd5;
   localparam logic [3:0] StFopQ  = 4'd6;
   localparam logic [3:0] StFarg  = 4'd7;
   localparam logic [3:0] StFargQ = 4'd8;
   localparam logic [3:0] StSrc   = 4'd9;
   localparam logic [3:0] StSrcQ  = 4'd10;
   localparam logic [3:0] StExec  = 4'd11;
   localparam logic [3:0] StWb    = 4'd12;
   localparam logic [3:0] StResp  = 4'd13;

   localparam logic [1:0] WaitLast = 2'd2;

   logic [3:0]             state_ff, state_in;
   logic [1:0]             cnt_ff, cnt_in;
   logic [AddrW-1:0]       clr_ff, clr_in;
   acc_pkg::cpu_regs_type  regs_ff, regs_in;
   acc_pkg::cpu_regs_type  exec_nxt;
   acc_pkg::req_word_type  req_ff, req_in;
   logic [15:0]            opword_ff, opword_in;
   logic [15:0]            operand_ff, operand_in;
   logic [15:0]            source_ff, source_in;
   logic [15:0]            rd_ff, rd_in;

   logic [15:0]            wrap_a;
   logic [AddrW-1:0]       wrap_idx;
   logic                   ram_we;
   logic [AddrW-1:0]       ram_addr;
   logic [15:0]            ram_wdata;
   logic [15:0]            ram_rdata;
   logic [1:0]             mode;
   logic                   dir_in;
   logic                   addr_ready;
   logic [15:0]            eff_addr;

   assign mode       = 2'(opword_ff & acc_pkg::ModeMask);
   assign dir_in     = |(opword_ff & acc_pkg::DirMask);
   assign addr_ready = (cnt_ff == WaitLast);

   // Effective address from the current registers
   always_comb begin
      case (mode)
         acc_pkg::ModeAbs: begin
            eff_addr = operand_ff;
         end
         acc_pkg::ModeIdx: begin
            eff_addr = regs_ff.address_reg + operand_ff;
         end
         default: begin
            eff_addr = regs_ff.program_counter + operand_ff;
         end
      endcase
   end

   // Select the address to reduce
   always_comb begin
      case (state_ff)
         StLoad, StRead: begin
            wrap_a = 16'(req_ff.mem_address);
         end
         StFop, StFarg: begin
            wrap_a = regs_ff.program_counter;
         end
         StSrc, StWb: begin
            wrap_a = eff_addr;
         end
         default: begin
            wrap_a = 16'd0;
         end
      endcase
   end

   acc_wrap #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_wrap (
      .clock (clock),
      .addr  (wrap_a),
      .idx   (wrap_idx)
   );

   // Memory port: clearing pass, load, write-back, or reads
   always_comb begin
      ram_addr  = wrap_idx;
      ram_wdata = regs_ff.held;
      ram_we    = 1'b0;
      case (state_ff)
         StClear: begin
            ram_addr  = clr_ff;
            ram_wdata = 16'd0;
            ram_we    = 1'b1;
         end
         StLoad: begin
            ram_wdata = req_ff.mem_data;
            ram_we    = addr_ready;
         end
         StWb: begin
            ram_we = addr_ready;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   acc_ram #(
      .WIDTH (16),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   acc_exec u_exec (
      .cur     (regs_ff),
      .opword  (opword_ff),
      .operand (operand_ff),
      .source  (source_ff),
      .nxt     (exec_nxt)
   );

   // Sequence one word at a time
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      clr_in     = clr_ff;
      regs_in    = regs_ff;
      req_in     = req_ff;
      opword_in  = opword_ff;
      operand_in = operand_ff;
      source_in  = source_ff;
      rd_in      = rd_ff;
      case (state_ff)
         StClear: begin
            clr_in = clr_ff + AddrW'(1);
            if (clr_ff == AddrW'(MEM_DEPTH - 1)) begin
               state_in = StIdle;
            end
         end
         StIdle: begin
            if (start) begin
               req_in = req_word;
               rd_in  = 16'd0;
               cnt_in = 2'd0;
               case (req_word.operation)
                  acc_pkg::OpLoad: begin
                     state_in = StLoad;
                  end
                  acc_pkg::OpRead: begin
                     state_in = StRead;
                  end
                  acc_pkg::OpExec: begin
                     state_in = regs_ff.halted ? StResp : StFop;
                  end
                  default: begin
                     state_in = StResp;
                  end
               endcase
            end
         end
         StLoad, StRead, StFop, StFarg, StSrc, StWb: begin
            cnt_in = cnt_ff + 2'd1;
            if (addr_ready) begin
               cnt_in = 2'd0;
               case (state_ff)
                  StRead: begin
                     state_in = StReadQ;
                  end
                  StFop: begin
                     state_in = StFopQ;
                  end
                  StFarg: begin
                     state_in = StFargQ;
                  end
                  StSrc: begin
                     state_in = StSrcQ;
                  end
                  default: begin
                     state_in = StResp;
                  end
               endcase
            end
         end
         StReadQ: begin
            rd_in    = ram_rdata;
            state_in = StResp;
         end
         StFopQ: begin
            opword_in               = ram_rdata;
            regs_in.program_counter = regs_ff.program_counter + 16'd1;
            state_in                = StFarg;
         end
         StFargQ: begin
            operand_in              = ram_rdata;
            source_in               = ram_rdata;
            regs_in.program_counter = regs_ff.program_counter + 16'd1;
            state_in = (mode == acc_pkg::ModeLit) ? StExec : StSrc;
         end
         StSrcQ: begin
            source_in = ram_rdata;
            state_in  = StExec;
         end
         StExec: begin
            regs_in = exec_nxt;
            if (!dir_in && (mode != acc_pkg::ModeLit)) begin
               state_in = StWb;
            end else begin
               state_in = StResp;
            end
         end
         StResp: begin
            state_in = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StClear;
         cnt_ff   <= 2'd0;
         clr_ff   <= '0;
         regs_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         clr_ff   <= clr_in;
         regs_ff  <= regs_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      opword_ff  <= opword_in;
      operand_ff <= operand_in;
      source_ff  <= source_in;
      rd_ff      <= rd_in;
   end

   // Drive the result word from the registers
   assign busy                     = (state_ff != StIdle);
   assign rsp_strobe               = (state_ff == StResp);
   assign rsp_word.data_reg        = regs_ff.data_reg;
   assign rsp_word.address_reg     = regs_ff.address_reg;
   assign rsp_word.program_counter = regs_ff.program_counter;
   assign rsp_word.zero_flag       = regs_ff.zero_flag;
   assign rsp_word.halted          = regs_ff.halted;
   assign rsp_word.read_word       = rd_ff;

`ifndef SYNTHESIS
   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      regs_ff.halted |=> regs_ff.halted)
      else $error("halted flag cleared without reset");

   a_no_write_on_fetch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StFop || state_ff == StFarg || state_ff == StSrc) |-> !ram_we)
      else $error("memory write during a read phase");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != StClear && addr_ready) |-> (32'(wrap_idx) < MEM_DEPTH))
      else $error("reduced address out of range");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_accumulator_cpu_core_top.sv =====
`timescale 1ns / 1ps

module tb_accumulator_cpu_core_top;

   localparam int unsigned MemDepth = 256;
   // operation code the core must ignore
   localparam logic [1:0] OpSpare = 2'd3;

   // Shadow copy of the core: registers, flags and memory after every accepted word
   class core_shadow;
      logic [15:0]           mem [MemDepth];
      logic [15:0]           d;
      logic [15:0]           a;
      logic [15:0]           pc;
      logic [15:0]           held;
      logic                  zf;
      logic                  stopped;
      acc_pkg::rsp_word_type due_states[$];
      int unsigned           errors;

      function new();
         foreach (mem[i]) mem[i] = '0;
         d = '0;
         a = '0;
         pc = '0;
         held = '0;
         zf = 1'b0;
         stopped = 1'b0;
         errors = 0;
      endfunction

      function logic [7:0] wrap(logic [15:0] x);
         return 8'(x % MemDepth);
      endfunction

      function void jump(logic [1:0] mode, logic [15:0] operand);
         if (mode == acc_pkg::ModeAbs) pc = operand;
         else if (mode == acc_pkg::ModeLit) pc = pc + operand;
      endfunction

      function void run_instruction();
         logic [15:0] opword;
         logic [15:0] operand;
         logic [15:0] src;
         logic [15:0] t;
         logic [15:0] ea;
         logic [1:0]  mode;
         logic        dir;
         logic [11:0] code;
         // fetch opcode and operand words
         opword = mem[wrap(pc)];
         pc = pc + 16'd1;
         operand = mem[wrap(pc)];
         pc = pc + 16'd1;
         mode = 2'(opword & acc_pkg::ModeMask);
         dir = |(opword & acc_pkg::DirMask);
         code = 12'(opword >> acc_pkg::CodeLsb);
         // resolve the source
         case (mode)
            acc_pkg::ModeAbs: src = mem[wrap(operand)];
            acc_pkg::ModeLit: src = operand;
            acc_pkg::ModeIdx: begin
               ea = a + operand;
               src = mem[wrap(ea)];
            end
            default: begin
               ea = pc + operand;
               src = mem[wrap(ea)];
            end
         endcase
         // execute
         case (code)
            acc_pkg::CodeMove: begin
               if (!dir) held = d;
               else d = src;
               zf = (d == 16'd0);
            end
            acc_pkg::CodeAdd: begin
               t = d + src;
               if (!dir) held = t;
               else d = t;
               zf = (t == 16'd0);
            end
            acc_pkg::CodeSub: begin
               t = d - src;
               if (!dir) held = t;
               else d = t;
               zf = (t == 16'd0);
            end
            acc_pkg::CodeBra: jump(mode, operand);
            acc_pkg::CodeCmp: begin
               t = d - src;
               zf = (t == 16'd0);
            end
            acc_pkg::CodeBeq: if (zf) jump(mode, operand);
            acc_pkg::CodeBne: if (!zf) jump(mode, operand);
            acc_pkg::CodeExg: begin
               t = d;
               d = a;
               a = t;
            end
            acc_pkg::CodeStop: stopped = 1'b1;
            default: ;
         endcase
         // write back with the address as it stands after execution
         if (!dir) begin
            case (mode)
               acc_pkg::ModeAbs: mem[wrap(operand)] = held;
               acc_pkg::ModeIdx: begin
                  ea = a + operand;
                  mem[wrap(ea)] = held;
               end
               acc_pkg::ModeRel: begin
                  ea = pc + operand;
                  mem[wrap(ea)] = held;
               end
               default: ;
            endcase
         end
      endfunction

      // Advance the shadow by one accepted word and queue the state it must report
      function void note_word(acc_pkg::req_word_type w);
         acc_pkg::rsp_word_type r;
         logic [15:0]           rd;
         rd = '0;
         case (w.operation)
            acc_pkg::OpLoad: mem[wrap({8'h00, w.mem_address})] = w.mem_data;
            acc_pkg::OpExec: if (!stopped) run_instruction();
            acc_pkg::OpRead: rd = mem[wrap({8'h00, w.mem_address})];
            default: ;
         endcase
         r.data_reg = d;
         r.address_reg = a;
         r.program_counter = pc;
         r.zero_flag = zf;
         r.halted = stopped;
         r.read_word = rd;
         due_states.push_back(r);
      endfunction

      function void compare(string field, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $error("%s: expected %h, got %h", field, want, got);
            errors++;
         end
      endfunction

      // Compare a result word against the oldest queued state
      function void check_word(acc_pkg::rsp_word_type got);
         acc_pkg::rsp_word_type want;
         if (due_states.size() == 0) begin
            $error("result word with nothing outstanding: %h", got);
            errors++;
            return;
         end
         want = due_states.pop_front();
         compare("data_reg", want.data_reg, got.data_reg);
         compare("address_reg", want.address_reg, got.address_reg);
         compare("program_counter", want.program_counter, got.program_counter);
         compare("zero_flag", 16'(want.zero_flag), 16'(got.zero_flag));
         compare("halted", 16'(want.halted), 16'(got.halted));
         compare("read_word", want.read_word, got.read_word);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   acc_pkg::req_word_type req_word = '0;
   logic                  busy;
   logic                  rsp_strobe;
   acc_pkg::rsp_word_type rsp_word;

   core_shadow   shadow;
   int unsigned  words_sent = 0;
   int unsigned  gap_pct = 11;

   accumulator_cpu_core_top #(
      .MEM_DEPTH(MemDepth)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_word(req_word),
      .busy(busy),
      .rsp_strobe(rsp_strobe),
      .rsp_word(rsp_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Check every strobed result word
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) shadow.check_word(rsp_word);
   end

   // Present one word, with an occasional gap first, and hold it until taken
   task automatic send_word(input logic [1:0] op, input logic [7:0] addr,
                            input logic [15:0] data);
      acc_pkg::req_word_type w;
      w.operation = op;
      w.mem_address = addr;
      w.mem_data = data;
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(24, 1)) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      shadow.note_word(w);
      words_sent++;
   endtask

   task automatic put_word(input logic [7:0] addr, input logic [15:0] data);
      send_word(acc_pkg::OpLoad, addr, data);
   endtask

   task automatic fetch_word(input logic [7:0] addr);
      send_word(acc_pkg::OpRead, addr, 16'($urandom));
   endtask

   task automatic step_cpu();
      send_word(acc_pkg::OpExec, 8'($urandom), 16'($urandom));
   endtask

   // Hold off the sender until every outstanding result has come back
   task automatic wait_drained();
      start <= 1'b0;
      while (shadow.due_states.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] opword_of(logic [11:0] code, logic dir, logic [1:0] mode);
      return {code, 1'b0, dir, mode};
   endfunction

   // Load an instruction at the current program counter and run it
   task automatic place_and_step(input logic [15:0] ow, input logic [15:0] operand);
      logic [15:0] next_pc;
      next_pc = shadow.pc + 16'd1;
      put_word(shadow.wrap(shadow.pc), ow);
      put_word(shadow.wrap(next_pc), operand);
      step_cpu();
   endtask

   function automatic logic step_is_safe();
      return 12'(shadow.mem[shadow.wrap(shadow.pc)] >> acc_pkg::CodeLsb) != acc_pkg::CodeStop;
   endfunction

   task automatic random_noise();
      case ($urandom_range(2))
         0: put_word(8'($urandom), 16'($urandom));
         1: fetch_word(8'($urandom));
         default: send_word(OpSpare, 8'($urandom), 16'($urandom));
      endcase
   endtask

   // Well-formed instruction with random content; stop is kept for the end
   task automatic random_instruction();
      logic [11:0] code;
      logic [1:0]  mode;
      logic        dir;
      logic [15:0] ow;
      logic [15:0] operand;
      logic [15:0] ea;
      if ($urandom_range(99) < 85) code = 12'($urandom_range(7));
      else if ($urandom_range(1)) code = 12'($urandom_range(14, 8));
      else code = 12'($urandom_range(4095, 16));
      mode = 2'($urandom_range(3));
      dir = 1'($urandom_range(1));
      ow = opword_of(code, dir, mode);
      ow[3] = 1'($urandom_range(1));
      case ($urandom_range(3))
         0: operand = 16'($urandom_range(15));
         1: operand = shadow.d;
         default: operand = 16'($urandom);
      endcase
      case (mode)
         acc_pkg::ModeAbs: ea = operand;
         acc_pkg::ModeIdx: ea = shadow.a + operand;
         default: ea = shadow.pc + 16'd2 + operand;
      endcase
      // seed the source, often equal to the data register to hit a zero result
      if (mode != acc_pkg::ModeLit && $urandom_range(1))
         put_word(shadow.wrap(ea), $urandom_range(2) == 0 ? shadow.d : 16'($urandom));
      place_and_step(ow, operand);
      if ($urandom_range(3) == 0) fetch_word(shadow.wrap(ea));
   endtask

   initial begin
      int unsigned pick;
      bit          drained_mid;
      drained_mid = 1'b0;
      shadow = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // field extremes and the ignored operation code
      put_word(8'hFF, 16'hFFFF);
      fetch_word(8'hFF);
      send_word(OpSpare, 8'hFF, 16'hFFFF);
      fetch_word(8'h00);
      // literal move of the sign bit
      place_and_step(opword_of(acc_pkg::CodeMove, 1'b1, acc_pkg::ModeLit), 16'h8000);
      // exchange, then indexed write-back through the swapped address register
      place_and_step(opword_of(acc_pkg::CodeExg, 1'b0, acc_pkg::ModeIdx), 16'h0001);
      // literal write-back stores nothing
      place_and_step(opword_of(acc_pkg::CodeSub, 1'b0, acc_pkg::ModeLit), 16'h0001);
      // relative branch leaves the counter alone but still writes back after it
      place_and_step(opword_of(acc_pkg::CodeBra, 1'b0, acc_pkg::ModeRel), 16'h0005);
      // taken branch near the top of the counter range, fetches wrap
      place_and_step(opword_of(acc_pkg::CodeBne, 1'b1, acc_pkg::ModeAbs), 16'hFFFE);
      place_and_step(opword_of(acc_pkg::CodeCmp, 1'b1, acc_pkg::ModeAbs), 16'h00FF);
      // unknown code still writes back
      place_and_step(opword_of(12'hABC, 1'b0, acc_pkg::ModeAbs), 16'h0080);
      wait_drained();

      while (words_sent < 550) begin
         gap_pct = (words_sent >= 250 && words_sent < 350) ? 0 : 11;
         if (words_sent >= 420 && !drained_mid) begin
            wait_drained();
            drained_mid = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 70) begin
            random_instruction();
         end else if (pick < 85) begin
            random_noise();
         end else if (pick < 95) begin
            // run whatever memory holds
            if (step_is_safe()) step_cpu();
            else fetch_word(8'($urandom));
         end else begin
            // broken sequence: opcode only, then noise
            put_word(shadow.wrap(shadow.pc), 16'($urandom));
            random_noise();
         end
      end

      // halt, then show that steps are ignored while memory access still works
      place_and_step(opword_of(acc_pkg::CodeStop, 1'($urandom_range(1)),
                               2'($urandom_range(3))),
                     16'($urandom));
      step_cpu();
      step_cpu();
      put_word(8'($urandom), 16'($urandom));
      fetch_word(8'($urandom));
      step_cpu();

      wait_drained();
      repeat (30) @(posedge clock);
      if (shadow.errors == 0) begin
         $display("tb_accumulator_cpu_core_top: clean");
      end else begin
         $display("tb_accumulator_cpu_core_top: errors");
      end
      $finish;
   end

   // Bound the run
   initial begin
      #2_000_000;
      $display("tb_accumulator_cpu_core_top: errors");
      $finish;
   end

endmodule
